[hw/rtl/tat_pkg.sv]
// Shared constants, codes and control types of the timed address allow table.
package tat_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ADDR_W        = 32;
    localparam int TIME_W        = 32;
    localparam int SLOT_W        = 3;
    localparam int ACT_W         = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_GRANT  = 2'd0,
        ACT_REVOKE = 2'd1,
        ACT_CHECK  = 2'd2
    } action_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic write_entry;
        logic clear_entry;
        logic report_ok;
    } tat_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic    present;
        action_t action;
        logic    hit;
        logic    free_found;
        logic    in_time;
    } tat_status_t;

endpackage

[hw/rtl/tat_ctrl.sv]
// Controller state machine of the timed address allow table.
module tat_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    input  tat_pkg::tat_status_t status,
    output tat_pkg::tat_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    logic   do_grant;
    logic   do_clear;
    logic   do_ok;

    always_comb
    begin
        do_grant = 1'b0;
        do_clear = 1'b0;
        do_ok    = 1'b0;
        if (status.present)
        begin
            unique case (status.action)
                tat_pkg::ACT_GRANT:
                begin
                    do_grant = status.hit || status.free_found;
                    do_ok    = status.hit || status.free_found;
                end
                tat_pkg::ACT_REVOKE:
                begin
                    do_clear = status.hit;
                    do_ok    = status.hit;
                end
                tat_pkg::ACT_CHECK:
                begin
                    do_clear = status.hit && !status.in_time;
                    do_ok    = status.hit && status.in_time;
                end
                default:
                begin
                    do_grant = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute     = 1'b1;
                cmd.write_entry = do_grant;
                cmd.clear_entry = do_clear;
                cmd.report_ok   = do_ok;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg == S_EXEC);
    assign done = done_reg;

    a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> (state_reg == S_IDLE))
        else $error("execute state held more than one cycle");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_EXEC))
        else $error("result strobe without an execute cycle");

    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done_reg)
        else $error("accepted transfer without a result two cycles later");

endmodule

[hw/rtl/tat_datapath.sv]
// Table storage, address lookup, deadline check and result registers.
module tat_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tat_pkg::tat_cmd_t           cmd,
    output tat_pkg::tat_status_t        status,
    input  logic [tat_pkg::ACT_W-1:0]   action,
    input  logic [tat_pkg::ADDR_W-1:0]  address,
    input  logic                        address_present,
    input  logic [tat_pkg::TIME_W-1:0]  now_time,
    input  logic [tat_pkg::TIME_W-1:0]  lifetime,
    output logic                        ok,
    output logic [tat_pkg::SLOT_W-1:0]  slot
);

    localparam int N     = tat_pkg::TABLE_ENTRIES;
    localparam int PAD_W = tat_pkg::IDX_W + tat_pkg::SLOT_W;

    logic [tat_pkg::ADDR_W-1:0] entry_address [N];
    logic [tat_pkg::TIME_W-1:0] entry_deadline [N];
    logic [N-1:0]               live_reg;

    logic [tat_pkg::ADDR_W-1:0] addr_reg;
    logic [tat_pkg::TIME_W-1:0] now_reg;
    logic [tat_pkg::TIME_W-1:0] life_reg;
    tat_pkg::action_t           action_reg;
    logic                       present_reg;
    logic                       hit_reg;
    logic                       free_reg;
    logic [tat_pkg::IDX_W-1:0]  match_idx_reg;
    logic [tat_pkg::IDX_W-1:0]  free_idx_reg;
    logic                       ok_reg;
    logic [tat_pkg::SLOT_W-1:0] slot_reg;

    logic                       hit_next;
    logic                       free_next;
    logic [tat_pkg::IDX_W-1:0]  match_idx_next;
    logic [tat_pkg::IDX_W-1:0]  free_idx_next;
    logic [tat_pkg::IDX_W-1:0]  sel_idx;
    logic [PAD_W-1:0]           sel_pad;
    logic [tat_pkg::TIME_W-1:0] diff;

    // lowest live match and lowest free entry, from the ports at transfer
    always_comb
    begin
        hit_next       = 1'b0;
        free_next      = 1'b0;
        match_idx_next = '0;
        free_idx_next  = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (live_reg[i] && (entry_address[i] == address))
            begin
                hit_next       = 1'b1;
                match_idx_next = tat_pkg::IDX_W'(i);
            end
            if (!live_reg[i])
            begin
                free_next     = 1'b1;
                free_idx_next = tat_pkg::IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg      <= address;
            now_reg       <= now_time;
            life_reg      <= lifetime;
            action_reg    <= tat_pkg::action_t'(action);
            present_reg   <= address_present;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            match_idx_reg <= match_idx_next;
            free_idx_reg  <= free_idx_next;
        end
    end

    assign diff    = entry_deadline[match_idx_reg] - now_reg;
    assign sel_idx = hit_reg ? match_idx_reg : free_idx_reg;
    assign sel_pad = PAD_W'(sel_idx);

    assign status.present    = present_reg;
    assign status.action     = action_reg;
    assign status.hit        = hit_reg;
    assign status.free_found = free_reg;
    assign status.in_time    = (diff != '0) && !diff[tat_pkg::TIME_W-1];

    always_ff @(posedge clk)
    begin
        if (cmd.write_entry)
        begin
            entry_address[sel_idx]  <= addr_reg;
            entry_deadline[sel_idx] <= now_reg + life_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            ok_reg   <= 1'b0;
            slot_reg <= '0;
        end
        else
        begin
            if (cmd.write_entry)
            begin
                live_reg[sel_idx] <= 1'b1;
            end
            else if (cmd.clear_entry)
            begin
                live_reg[match_idx_reg] <= 1'b0;
            end
            if (cmd.execute)
            begin
                ok_reg   <= cmd.report_ok;
                slot_reg <= cmd.report_ok ? sel_pad[tat_pkg::SLOT_W-1:0] : '0;
            end
        end
    end

    assign ok   = ok_reg;
    assign slot = slot_reg;

    a_write_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write_entry && cmd.clear_entry))
        else $error("entry written and cleared in the same cycle");

    a_no_slot_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        !ok_reg |-> (slot_reg == '0))
        else $error("slot nonzero on a failed transfer");

endmodule

[hw/rtl/timed_address_allow_table.sv]
// Top level of the timed address allow table: controller plus datapath.
// A transfer is looked up and captured when accepted; the update state writes the table and registers the result.
// No new transfer is taken until the current one has left the update state.
// busy is high during the update cycle; start is taken only while busy is low.
// Reset (rst_n low, async) clears all live bits, the state machine and the strobe.
// done is a one-cycle strobe; the receiver cannot stall it.
module timed_address_allow_table
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tat_pkg::ACT_W-1:0]   action,
    input  logic [tat_pkg::ADDR_W-1:0]  address,
    input  logic                        address_present,
    input  logic [tat_pkg::TIME_W-1:0]  now_time,
    input  logic [tat_pkg::TIME_W-1:0]  lifetime,
    output logic                        done,
    output logic                        ok,
    output logic [tat_pkg::SLOT_W-1:0]  slot
);

    tat_pkg::tat_cmd_t    cmd;
    tat_pkg::tat_status_t status;

    tat_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .status (status),
        .cmd    (cmd)
    );

    tat_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .action          (action),
        .address         (address),
        .address_present (address_present),
        .now_time        (now_time),
        .lifetime        (lifetime),
        .ok              (ok),
        .slot            (slot)
    );

endmodule

[test/timed_address_allow_table_test.sv]
// Self-checking testbench for the timed address allow table: bursty requests vs. a shadow table.
`timescale 1ns / 1ps

module timed_address_allow_table_test;

    localparam logic [tat_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int EFFECTIVE_ITEMS = 380;
    localparam int POOL_SIZE = 10;
    localparam int MAX_PRINTED = 100;

    typedef struct {
        logic [tat_pkg::ACT_W-1:0]  action;
        logic [tat_pkg::ADDR_W-1:0] address;
        logic                       present;
        logic [tat_pkg::TIME_W-1:0] now_ms;
        logic [tat_pkg::TIME_W-1:0] lifetime_ms;
    } access_request_t;

    typedef struct {
        logic                       ok;
        logic [tat_pkg::SLOT_W-1:0] slot;
    } access_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic [tat_pkg::ACT_W-1:0]  action = '0;
    logic [tat_pkg::ADDR_W-1:0] address = '0;
    logic                       address_present = 1'b0;
    logic [tat_pkg::TIME_W-1:0] now_time = '0;
    logic [tat_pkg::TIME_W-1:0] lifetime = '0;
    logic                       busy;
    logic                       done;
    logic                       ok;
    logic [tat_pkg::SLOT_W-1:0] slot;

    access_request_t pending_requests[$];
    access_result_t  expected_results[$];

    logic [tat_pkg::ADDR_W-1:0] shadow_address  [tat_pkg::TABLE_ENTRIES];
    logic [tat_pkg::TIME_W-1:0] shadow_deadline [tat_pkg::TABLE_ENTRIES];
    logic                       shadow_live     [tat_pkg::TABLE_ENTRIES];

    int issued_count = 0;
    int accepted_count = 0;
    int checked_count = 0;
    int error_count = 0;
    int burst_left = 0;
    int gap_left = 0;

    int grants_stored = 0;
    int grants_refused = 0;
    int checks_authorized = 0;
    int entries_expired = 0;
    int revokes_done = 0;
    int ignored_items = 0;

    timed_address_allow_table uut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .address         (address),
        .address_present (address_present),
        .now_time        (now_time),
        .lifetime        (lifetime),
        .done            (done),
        .ok              (ok),
        .slot            (slot)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < tat_pkg::TABLE_ENTRIES; i++)
        begin
            shadow_live[i] = 1'b0;
        end
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED)
        begin
            $display("[%0t] error: %s: got 0x%0h, expected 0x%0h",
                     $realtime, what, got, want);
        end
    endtask

    function automatic access_result_t predict_access(access_request_t req);
        access_result_t res;
        int hit;
        int free_idx;
        logic [tat_pkg::TIME_W-1:0] remaining;
        res.ok = 1'b0;
        res.slot = '0;
        hit = -1;
        free_idx = -1;
        if (!req.present || req.action == ACT_UNUSED)
        begin
            ignored_items++;
            return res;
        end
        for (int i = tat_pkg::TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (shadow_live[i] && shadow_address[i] == req.address)
                hit = i;
            if (!shadow_live[i])
                free_idx = i;
        end
        case (req.action)
            tat_pkg::ACT_GRANT:
            begin
                if (hit < 0)
                    hit = free_idx;
                if (hit >= 0)
                begin
                    shadow_address[hit] = req.address;
                    shadow_deadline[hit] = req.now_ms + req.lifetime_ms;
                    shadow_live[hit] = 1'b1;
                    res.ok = 1'b1;
                    res.slot = tat_pkg::SLOT_W'(hit);
                    grants_stored++;
                end
                else
                begin
                    grants_refused++;
                end
            end
            tat_pkg::ACT_REVOKE:
            begin
                if (hit >= 0)
                begin
                    shadow_live[hit] = 1'b0;
                    res.ok = 1'b1;
                    res.slot = tat_pkg::SLOT_W'(hit);
                    revokes_done++;
                end
            end
            tat_pkg::ACT_CHECK:
            begin
                if (hit >= 0)
                begin
                    remaining = shadow_deadline[hit] - req.now_ms;
                    if (remaining != '0 && !remaining[tat_pkg::TIME_W-1])
                    begin
                        res.ok = 1'b1;
                        res.slot = tat_pkg::SLOT_W'(hit);
                        checks_authorized++;
                    end
                    else
                    begin
                        shadow_live[hit] = 1'b0;
                        entries_expired++;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic queue_request(logic [tat_pkg::ACT_W-1:0] act,
                                 logic [tat_pkg::ADDR_W-1:0] addr,
                                 logic present, logic [tat_pkg::TIME_W-1:0] now_ms,
                                 logic [tat_pkg::TIME_W-1:0] life_ms);
        access_request_t req;
        req.action = act;
        req.address = addr;
        req.present = present;
        req.now_ms = now_ms;
        req.lifetime_ms = life_ms;
        pending_requests.push_back(req);
    endtask

    // driver: bursts with random gaps, item held until its transfer
    always @(negedge clk)
    begin : drive_requests
        access_request_t req;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || accepted_count == issued_count)
        begin
            if (gap_left > 0 || pending_requests.size() == 0)
            begin
                start <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                req = pending_requests.pop_front();
                action <= req.action;
                address <= req.address;
                address_present <= req.present;
                now_time <= req.now_ms;
                lifetime <= req.lifetime_ms;
                start <= 1'b1;
                issued_count <= issued_count + 1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // monitor: check result strobes, predict on each accepted transfer
    always @(posedge clk)
    begin : watch_results
        access_request_t req;
        access_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with no transfer pending", 32'({ok, slot}), 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (ok !== want.ok)
                        report_mismatch("ok", 32'(ok), 32'(want.ok));
                    if (slot !== want.slot)
                        report_mismatch("slot", 32'(slot), 32'(want.slot));
                    checked_count++;
                end
            end
            if (start && !busy)
            begin
                req.action = action;
                req.address = address;
                req.present = address_present;
                req.now_ms = now_time;
                req.lifetime_ms = lifetime;
                expected_results.push_back(predict_access(req));
                accepted_count <= accepted_count + 1;
            end
        end
    end

    initial
    begin : stimulus
        logic [tat_pkg::ADDR_W-1:0] pool [POOL_SIZE];
        logic [tat_pkg::TIME_W-1:0] clock_ms;
        logic [tat_pkg::TIME_W-1:0] now_ms;
        logic [tat_pkg::TIME_W-1:0] life_ms;
        logic [tat_pkg::ADDR_W-1:0] addr;
        logic [tat_pkg::ACT_W-1:0]  act;
        int effective;
        int pick;
        int wait_cycles;

        // directed part
        queue_request(tat_pkg::ACT_GRANT,  32'h0000_0000, 1'b1, 32'h0000_0000, 32'd100);
        queue_request(tat_pkg::ACT_GRANT,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(tat_pkg::ACT_CHECK,  32'h0000_0000, 1'b1, 32'd50,        32'h0);
        queue_request(tat_pkg::ACT_CHECK,  32'h0000_0000, 1'b0, 32'd50,        32'h0);
        queue_request(tat_pkg::ACT_GRANT,  32'h0000_0005, 1'b0, 32'd60,        32'd10);
        queue_request(ACT_UNUSED,          32'h0000_0000, 1'b1, 32'd60,        32'hFFFF_FFFF);
        queue_request(tat_pkg::ACT_CHECK,  32'h0000_0000, 1'b1, 32'd100,       32'h0);
        queue_request(tat_pkg::ACT_CHECK,  32'h0000_0000, 1'b1, 32'd100,       32'h0);
        queue_request(tat_pkg::ACT_REVOKE, 32'hFFFF_FFFF, 1'b1, 32'd110,       32'h0);
        queue_request(tat_pkg::ACT_REVOKE, 32'hFFFF_FFFF, 1'b1, 32'd120,       32'h0);
        queue_request(tat_pkg::ACT_GRANT,  32'h1234_5678, 1'b1, 32'h8000_0000, 32'h0);
        queue_request(tat_pkg::ACT_CHECK,  32'h1234_5678, 1'b1, 32'h8000_0000, 32'h0);
        for (int i = 0; i < tat_pkg::TABLE_ENTRIES; i++)
        begin
            queue_request(tat_pkg::ACT_GRANT, 32'hA0 + i, 1'b1, 32'h0, 32'h7FFF_FFFF);
        end
        queue_request(tat_pkg::ACT_GRANT,  32'hDEAD_BEEF, 1'b1, 32'h0,         32'd1000);
        queue_request(tat_pkg::ACT_GRANT,  32'hA3,        1'b1, 32'd10,        32'd20);
        // difference of exactly half the range counts as expired
        queue_request(tat_pkg::ACT_CHECK,  32'hA5,        1'b1, 32'hFFFF_FFFF, 32'h0);
        queue_request(tat_pkg::ACT_CHECK,  32'hA6,        1'b1, 32'h7FFF_FFFE, 32'h0);
        queue_request(tat_pkg::ACT_GRANT,  32'hA4,        1'b1, 32'h9000_0000, 32'd10);

        // random part: small address pool, mostly advancing time
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
        begin
            pool[i] = $urandom;
        end
        clock_ms = $urandom;
        effective = 0;
        while (effective < EFFECTIVE_ITEMS)
        begin
            if ($urandom_range(0, 99) < 3)
                clock_ms = clock_ms + $urandom;
            else
                clock_ms = clock_ms + $urandom_range(0, 40);
            now_ms = ($urandom_range(0, 99) < 3) ? $urandom : clock_ms;
            pick = $urandom_range(0, 99);
            if (pick < 60)
                life_ms = $urandom_range(0, 400);
            else if (pick < 75)
                life_ms = $urandom_range(0, 30);
            else if (pick < 90)
                life_ms = $urandom;
            else
                life_ms = 32'h7FFF_FFF0 + $urandom_range(0, 31);
            if ($urandom_range(0, 99) < 3)
                pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
            addr = ($urandom_range(0, 99) < 5) ? $urandom
                                               : pool[$urandom_range(0, POOL_SIZE - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 42)
            begin
                queue_request(tat_pkg::ACT_GRANT, addr, 1'b1, now_ms, life_ms);
                effective++;
            end
            else if (pick < 75)
            begin
                queue_request(tat_pkg::ACT_CHECK, addr, 1'b1, now_ms, life_ms);
                effective++;
            end
            else if (pick < 90)
            begin
                queue_request(tat_pkg::ACT_REVOKE, addr, 1'b1, now_ms, life_ms);
                effective++;
            end
            else if (pick < 95)
            begin
                queue_request(ACT_UNUSED, addr, 1'b1, now_ms, life_ms);
            end
            else
            begin
                act = tat_pkg::ACT_W'($urandom_range(0, 3));
                queue_request(act, addr, 1'b0, now_ms, life_ms);
            end
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_requests.size() != 0 || start || accepted_count != issued_count)
            @(posedge clk);
        wait_cycles = 0;
        while (expected_results.size() != 0 && wait_cycles < 100)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", 32'(expected_results.size()), 0);

        $display("Run covered %0d transfers, %0d results checked, %0d ignored items.",
                 accepted_count, checked_count, ignored_items);
        $display("Grants stored %0d, refused on full table %0d, checks authorized %0d,",
                 grants_stored, grants_refused, checks_authorized);
        $display("expired %0d, revokes %0d.", entries_expired, revokes_done);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout after %0d transfers", accepted_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/tat_pkg.sv
hw/rtl/tat_ctrl.sv
hw/rtl/tat_datapath.sv
hw/rtl/timed_address_allow_table.sv
test/timed_address_allow_table_test.sv
